// File: rtl/core/pld_pkg.sv
// Shared types, constants and the calibration table of the distance lookup.
package pld_pkg;

  localparam int AdcW       = 10;
  localparam int MmW        = 10;
  localparam int StatusW    = 2;
  localparam int TablePoints = 9;
  localparam int TableSlots = 16;
  localparam int QuotW      = 10;
  localparam int ProdW      = AdcW + QuotW;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [StatusW-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_NEAR = 2'd1,
    STATUS_FAR  = 2'd2
  } status_t;

  // Calibration points: falling converter codes against rising distances.
  // Slots past the last real point repeat it and only add zero-span segments.
  localparam logic [AdcW-1:0] PT_ADC [TableSlots] = '{
    10'd471, 10'd338, 10'd266, 10'd194, 10'd147, 10'd121, 10'd102, 10'd90, 10'd82,
    10'd82,  10'd82,  10'd82,  10'd82,  10'd82,  10'd82,  10'd82
  };

  localparam logic [MmW-1:0] PT_MM [TableSlots] = '{
    10'd100, 10'd150, 10'd200, 10'd300, 10'd400, 10'd500, 10'd600, 10'd700, 10'd800,
    10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800
  };

  // One classified item, ready for the arithmetic back end.
  typedef struct packed {
    status_t           status;
    logic [MmW-1:0]    base;
    logic [AdcW-1:0]   offset;
    logic [QuotW-1:0]  m_span;
    logic [AdcW-1:0]   a_span;
  } pld_item_t;

endpackage

// File: rtl/core/piecewise_linear_distance_lookup.sv
// Top level of the piecewise-linear distance lookup for an infrared range sensor.
//
// Input channel: drive adc_sample with start high; the item is taken at the
// rising edge where start is high and busy is low. busy stays low in normal
// operation, so a new sample can be offered in every cycle.
// Output channel: done is high for exactly one cycle with range_status and
// distance_mm; the result is taken at the edge that ends that cycle. The
// receiver cannot stall, so results leave in acceptance order, one per cycle.
// Path: the front register holds the segment-search result, the queue slot
// holds the item, then the product register, a restoring divide step for
// each quotient bit, and the final add into the output register. Throughput
// is one item per cycle.
// Status 0 means in range, 1 too close, 2 too far; distance is 0 unless the
// status is in range. A zero-span segment returns its start distance.
// Reset (synchronous, active high) empties the front register, the queue and
// all pipeline valid bits at once; items in flight are dropped and no result
// appears until new samples are accepted.
module piecewise_linear_distance_lookup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pld_pkg::AdcW-1:0]      adc_sample,
  output logic                          done,
  output logic [pld_pkg::StatusW-1:0]   range_status,
  output logic [pld_pkg::MmW-1:0]       distance_mm
);

  // Classified items pass from the front end into the queue.
  logic               push;
  logic               q_full;
  pld_pkg::pld_item_t front_item;

  // The queue drains into the back end whenever it holds an item.
  logic               q_vld;
  pld_pkg::pld_item_t q_item;

  pld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .adc_sample (adc_sample),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .item       (front_item)
  );

  pld_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_item  (front_item),
    .full     (q_full),
    .out_vld  (q_vld),
    .out_item (q_item)
  );

  pld_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (q_vld),
    .in_item      (q_item),
    .done         (done),
    .range_status (range_status),
    .distance_mm  (distance_mm)
  );

endmodule

// File: rtl/core/pld_front.sv
// Front end: takes samples, finds the bracketing segment and registers the item.
module pld_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pld_pkg::AdcW-1:0]     adc_sample,
  input  logic                         q_full,
  output logic                         busy,
  output logic                         push,
  output pld_pkg::pld_item_t           item
);

  logic               front_vld;
  logic               front_vld_next;
  logic               accept;
  pld_pkg::pld_item_t cls;

  assign push   = front_vld && !q_full;
  assign busy   = front_vld && q_full;
  assign accept = start && !busy;
  assign front_vld_next = accept || (front_vld && !push);

  always_comb begin
    logic found;
    found = 1'b0;
    cls.status = pld_pkg::STATUS_FAR;
    cls.base   = '0;
    cls.offset = '0;
    cls.m_span = '0;
    cls.a_span = pld_pkg::AdcW'(1);
    if (adc_sample > pld_pkg::PT_ADC[0]) begin
      cls.status = pld_pkg::STATUS_NEAR;
    end else if (adc_sample >= pld_pkg::PT_ADC[pld_pkg::TablePoints-1]) begin
      // Walk down from the last segment so the first bracketing one wins.
      for (int k = pld_pkg::TablePoints - 2; k >= 0; k--) begin
        if (adc_sample <= pld_pkg::PT_ADC[k] && adc_sample >= pld_pkg::PT_ADC[k+1]) begin
          found      = 1'b1;
          cls.base   = pld_pkg::PT_MM[k];
          if (pld_pkg::PT_ADC[k] == pld_pkg::PT_ADC[k+1]) begin
            cls.offset = '0;
            cls.m_span = '0;
            cls.a_span = pld_pkg::AdcW'(1);
          end else begin
            cls.offset = pld_pkg::PT_ADC[k] - adc_sample;
            cls.m_span = pld_pkg::QuotW'(pld_pkg::PT_MM[k+1] - pld_pkg::PT_MM[k]);
            cls.a_span = pld_pkg::PT_ADC[k] - pld_pkg::PT_ADC[k+1];
          end
        end
      end
      if (found) begin
        cls.status = pld_pkg::STATUS_OK;
      end else begin
        cls.base = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_vld <= 1'b0;
    end else begin
      front_vld <= front_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cls;
    end
  end

endmodule

// File: rtl/core/pld_queue.sv
// Short queue between the front end and the arithmetic back end.
module pld_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pld_pkg::pld_item_t  in_item,
  output logic                full,
  output logic                out_vld,
  output pld_pkg::pld_item_t  out_item
);

  pld_pkg::pld_item_t               slots [pld_pkg::QueueDepth];
  logic [pld_pkg::QueuePtrW-1:0]    wr_ptr;
  logic [pld_pkg::QueuePtrW-1:0]    rd_ptr;
  logic [pld_pkg::QueueCntW-1:0]    count;
  logic [pld_pkg::QueueCntW-1:0]    count_next;
  logic                             pop;

  // The back end never stalls, so anything present leaves at once.
  assign out_vld  = (count != '0);
  assign pop      = out_vld;
  assign full     = (count == pld_pkg::QueueCntW'(pld_pkg::QueueDepth));
  assign out_item = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// File: rtl/core/pld_back.sv
// Back end: multiply, pipelined restoring divide and final add.
module pld_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  pld_pkg::pld_item_t            in_item,
  output logic                          done,
  output logic [pld_pkg::StatusW-1:0]   range_status,
  output logic [pld_pkg::MmW-1:0]       distance_mm
);

  localparam int Stages = pld_pkg::QuotW;

  // Index 0 holds the product stage; index j holds the result of divide step j.
  logic                         st_vld    [Stages+1];
  logic [pld_pkg::ProdW-1:0]    st_rem    [Stages+1];
  logic [pld_pkg::AdcW-1:0]     st_div    [Stages+1];
  logic [pld_pkg::QuotW-1:0]    st_quo    [Stages+1];
  logic [pld_pkg::MmW-1:0]      st_base   [Stages+1];
  pld_pkg::status_t             st_status [Stages+1];
  logic [pld_pkg::MmW:0]        sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld[0] <= 1'b0;
    end else begin
      st_vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    st_rem[0]    <= pld_pkg::ProdW'(in_item.offset) * pld_pkg::ProdW'(in_item.m_span);
    st_div[0]    <= in_item.a_span;
    st_quo[0]    <= '0;
    st_base[0]   <= in_item.base;
    st_status[0] <= in_item.status;
  end

  // The offset never exceeds the span, so the quotient fits in QuotW bits.
  for (genvar j = 1; j <= Stages; j++) begin : g_div
    logic [pld_pkg::ProdW-1:0] trial;
    logic                      take;

    assign trial = {{(pld_pkg::ProdW-pld_pkg::AdcW){1'b0}}, st_div[j-1]} << (Stages - j);
    assign take  = (st_rem[j-1] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[j] <= 1'b0;
      end else begin
        st_vld[j] <= st_vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      st_rem[j]    <= take ? (st_rem[j-1] - trial) : st_rem[j-1];
      st_quo[j]    <= st_quo[j-1] | (pld_pkg::QuotW'(take) << (Stages - j));
      st_div[j]    <= st_div[j-1];
      st_base[j]   <= st_base[j-1];
      st_status[j] <= st_status[j-1];
    end
  end

  assign sum = {1'b0, st_base[Stages]} + {1'b0, st_quo[Stages]};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st_vld[Stages];
    end
  end

  always_ff @(posedge clk) begin
    range_status <= st_status[Stages];
    distance_mm  <= sum[pld_pkg::MmW-1:0];
  end

endmodule

// File: rtl/core/pld_checker.sv
// Port-level assertions for the distance lookup and the bind that attaches them.
module pld_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [pld_pkg::AdcW-1:0]      adc_sample,
  input logic                          done,
  input logic [pld_pkg::StatusW-1:0]   range_status,
  input logic [pld_pkg::MmW-1:0]       distance_mm
);

  // The back end drains the queue every cycle, so the block never pushes back.
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted although the back end never stalls");

  // Every accepted sample is answered by a result with done high.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##14 done)
    else $error("result missing at the expected latency");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && range_status != pld_pkg::STATUS_OK) |-> (distance_mm == '0))
    else $error("nonzero distance on an out-of-range result");

  a_in_range_bounds: assert property (@(posedge clk) disable iff (rst)
    (done && range_status == pld_pkg::STATUS_OK) |->
      (distance_mm >= pld_pkg::PT_MM[0] &&
       distance_mm <= pld_pkg::PT_MM[pld_pkg::TablePoints-1]))
    else $error("in-range distance outside the table span");

  a_near_sample: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && adc_sample > pld_pkg::PT_ADC[0]) |->
      ##14 (range_status == pld_pkg::STATUS_NEAR))
    else $error("sample above the first point not reported as too close");

endmodule

bind piecewise_linear_distance_lookup pld_checker u_pld_checker (.*);
